// ===== rtl/core/msp_pkg.sv =====
`timescale 1ns / 1ps

package msp_pkg;

  localparam int MotorCountDef = 15;
  localparam int GroupSizeDef  = 5;

  localparam int LevelW  = 15;
  localparam int HeightW = 16;
  localparam int DelayW  = 16;
  localparam int IndexW  = 4;
  localparam int DivW    = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;

  localparam logic [HeightW-1:0] HeightLimitRst = 16'd345;
  localparam logic [DivW-1:0]    StepDividerRst = 8'd50;

  // item kinds
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_START_DELAY  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GROUP1_DELAY = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GROUP2_DELAY = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STEP_DIVIDER = 3'd4;

  typedef struct packed {
    logic               action;
    logic [IndexW-1:0]  motor_index;
    logic [HeightW-1:0] target_height;
    logic [DelayW-1:0]  elapsed_delay;
  } in_t;

  typedef struct packed {
    logic [LevelW-1:0] pulse_levels;
    logic [LevelW-1:0] direction_levels;
  } out_t;

  // per-motor control from the top level
  typedef struct packed {
    logic               tick_en;
    logic               store_en;
    logic [HeightW-1:0] target;
    logic [HeightW-1:0] height_limit;
    logic [DivW-1:0]    step_divider;
  } motor_ctl_t;

  typedef struct packed {
    logic pulse;
    logic dir;
  } lvl_t;

endpackage

// ===== rtl/core/multi_stepper_position_follower.sv =====
`timescale 1ns / 1ps

// Stepper position follower for MOTOR_COUNT motors in groups of GROUP_SIZE. A store beat
// sets one motor's target height; a tick beat compares its delay count with the group
// thresholds and advances every running motor of an enabled group at once, toggling its
// pulse level and moving its position one unit each step_divider+1 ticks. Every input beat
// gives one result beat carrying the pulse and direction levels after that beat. One beat
// is accepted per cycle while in_stall_o is low; a beat is held in the input register, and
// its motor update is done in a single pass as it moves into the output register.
// The output register lets the next beat be taken while a result still waits.
module multi_stepper_position_follower
  import msp_pkg::*;
#(
  parameter int MOTOR_COUNT = MotorCountDef,
  parameter int GROUP_SIZE  = GroupSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  logic [DelayW-1:0]  start_delay_q, group1_delay_q, group2_delay_q;
  logic [HeightW-1:0] height_limit_q;
  logic [DivW-1:0]    step_divider_q;

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q, out_d;
  logic advance;
  logic en0, en1, en2;

  logic [MOTOR_COUNT-1:0] cur_pulse, cur_dir, nxt_pulse, nxt_dir;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q  <= '0;
      group1_delay_q <= '0;
      group2_delay_q <= '0;
      height_limit_q <= HeightLimitRst;
      step_divider_q <= StepDividerRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_DELAY:  start_delay_q  <= cfg_wdata_i[DelayW-1:0];
        REG_GROUP1_DELAY: group1_delay_q <= cfg_wdata_i[DelayW-1:0];
        REG_GROUP2_DELAY: group2_delay_q <= cfg_wdata_i[DelayW-1:0];
        REG_HEIGHT_LIMIT: height_limit_q <= cfg_wdata_i[HeightW-1:0];
        REG_STEP_DIVIDER: step_divider_q <= cfg_wdata_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // the held beat moves on whenever the output register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign en0 = in_q.elapsed_delay > start_delay_q;
  assign en1 = en0 && (in_q.elapsed_delay > group1_delay_q);
  assign en2 = en1 && (in_q.elapsed_delay > group2_delay_q);

  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_motor
    localparam int Grp = m / GROUP_SIZE;
    motor_ctl_t ctl;
    lvl_t       cur, nxt;
    logic       grp_en;

    if (Grp == 0) begin : g_g0
      assign grp_en = en0;
    end else if (Grp == 1) begin : g_g1
      assign grp_en = en1;
    end else begin : g_gn
      assign grp_en = en2;
    end

    assign ctl.tick_en      = advance && (in_q.action == ACT_TICK) && grp_en;
    assign ctl.store_en     = advance && (in_q.action == ACT_STORE)
                              && (int'(in_q.motor_index) == m);
    assign ctl.target       = in_q.target_height;
    assign ctl.height_limit = height_limit_q;
    assign ctl.step_divider = step_divider_q;

    msp_motor u_motor (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .cur_o  (cur),
      .nxt_o  (nxt)
    );

    assign cur_pulse[m] = cur.pulse;
    assign cur_dir[m]   = cur.dir;
    assign nxt_pulse[m] = nxt.pulse;
    assign nxt_dir[m]   = nxt.dir;
  end

  // only the first fifteen motors reach the result
  for (genvar b = 0; b < LevelW; b++) begin : g_lvl
    if (b < MOTOR_COUNT) begin : g_on
      assign out_d.pulse_levels[b]     = nxt_pulse[b];
      assign out_d.direction_levels[b] = nxt_dir[b];
    end else begin : g_off
      assign out_d.pulse_levels[b]     = 1'b0;
      assign out_d.direction_levels[b] = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a waiting beat must move once the output side takes
  a_beat_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_stall_i |=> out_valid_q)
    else $error("held beat did not reach output register");

  // a store beat moves no motor
  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.action == ACT_STORE) |->
      (nxt_pulse == cur_pulse) && (nxt_dir == cur_dir))
    else $error("store beat changed motor levels");

  // a tick at or below the start threshold moves no motor
  a_tick_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.action == ACT_TICK) && !(in_q.elapsed_delay > start_delay_q) |->
      (nxt_pulse == cur_pulse) && (nxt_dir == cur_dir))
    else $error("motor moved with all groups disabled");

endmodule

// ===== rtl/core/msp_motor.sv =====
`timescale 1ns / 1ps

module msp_motor
  import msp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  motor_ctl_t ctl_i,
  output lvl_t       cur_o,
  output lvl_t       nxt_o
);

  logic [HeightW-1:0] target_q, target_d;
  logic [HeightW-1:0] pos_q, pos_d;
  logic [DivW-1:0]    cnt_q, cnt_d;
  logic               dir_q, dir_d;
  logic               pulse_q, pulse_d;
  logic               active;
  logic [DivW:0]      cnt_inc;
  logic               step;

  assign active  = (target_q <= ctl_i.height_limit) && (target_q != pos_q);
  // nine bits so that a divider of 255 still steps
  assign cnt_inc = {1'b0, cnt_q} + {{DivW{1'b0}}, 1'b1};
  assign step    = cnt_inc > {1'b0, ctl_i.step_divider};

  always_comb begin
    target_d = target_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    dir_d    = dir_q;
    pulse_d  = pulse_q;
    if (ctl_i.store_en) begin
      target_d = ctl_i.target;
    end
    if (ctl_i.tick_en && active) begin
      pulse_d = ~pulse_q;
      if (step) begin
        cnt_d = '0;
        dir_d = target_q < pos_q;
        pos_d = dir_d ? pos_q - {{(HeightW-1){1'b0}}, 1'b1}
                      : pos_q + {{(HeightW-1){1'b0}}, 1'b1};
      end else begin
        cnt_d = cnt_inc[DivW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      dir_q    <= 1'b0;
      pulse_q  <= 1'b0;
    end else begin
      target_q <= target_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      dir_q    <= dir_d;
      pulse_q  <= pulse_d;
    end
  end

  assign cur_o = '{pulse: pulse_q, dir: dir_q};
  assign nxt_o = '{pulse: pulse_d, dir: dir_d};

endmodule
